[rtl/reed_solomon_systematic_encoder_defines.svh]
// assertion macros used by the encoder top module
`ifndef REED_SOLOMON_SYSTEMATIC_ENCODER_DEFINES_SVH
`define REED_SOLOMON_SYSTEMATIC_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RSE_ASSERT_SAME(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rse: same-cycle check failed");

// next-cycle implication
`define RSE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rse: next-cycle check failed");

`else

`define RSE_ASSERT_SAME(name, clk, rstn, ante, cons)
`define RSE_ASSERT_NEXT(name, clk, rstn, ante, cons)

`endif

`endif

[rtl/rse_pkg.sv]
`default_nettype none

package rse_pkg;

  localparam int unsigned MaxParity   = 32;
  localparam int unsigned CountW      = 6;
  localparam int unsigned SymW        = 8;
  localparam int unsigned ResetParity = 16;

  localparam logic [SymW:0]   FieldPoly = 9'h11d;
  localparam logic [SymW:0]   FieldTop  = 9'h100;

  typedef struct packed {
    logic            cfg_clear;
    logic            accept;
    logic            last;
    logic            shift_out;
    logic            gen_step;
    logic [SymW-1:0] fb;
    logic [SymW-1:0] root;
  } cell_ctrl_t;

  // multiply by alpha
  function automatic logic [SymW-1:0] gf_xtime(input logic [SymW-1:0] x);
    logic [SymW:0] s;
    s = {x, 1'b0};
    if ((s & FieldTop) != '0) begin
      s = s ^ FieldPoly;
    end
    return s[SymW-1:0];
  endfunction

  function automatic logic [SymW-1:0] gf_mul(input logic [SymW-1:0] a,
                                             input logic [SymW-1:0] b);
    logic [SymW-1:0] x;
    logic [SymW-1:0] acc;
    x   = a;
    acc = '0;
    for (int i = 0; i < SymW; i++) begin
      if (b[i]) begin
        acc = acc ^ x;
      end
      x = gf_xtime(x);
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

[rtl/rse_if.sv]
`default_nettype none

interface rse_in_if;
  import rse_pkg::*;
  logic            valid;
  logic            ready;
  logic [SymW-1:0] data_byte;
  logic            last_byte;
  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rse_out_if;
  import rse_pkg::*;
  logic            valid;
  logic            ready;
  logic [SymW-1:0] out_byte;
  logic            is_parity;
  logic            end_of_codeword;
  modport source (output valid, output out_byte, output is_parity,
                  output end_of_codeword, input ready);
  modport sink   (input valid, input out_byte, input is_parity,
                  input end_of_codeword, output ready);
endinterface

`default_nettype wire

[rtl/reed_solomon_systematic_encoder.sv]
// a message byte appears at the output register in the cycle after its transfer
// one message byte per cycle while no drain or derivation runs and the output can load;
//   after the last byte the n parity bytes leave while input is held off
// the rate is set by the row of lfsr cells, all stages updating in parallel per byte
// reset: parity cleared, parity_count = 16, then the generator is derived one factor
//   per step with input held off; a parity_count write clears parity and rederives it
`include "reed_solomon_systematic_encoder_defines.svh"
`default_nettype none

module reed_solomon_systematic_encoder (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [rse_pkg::CountW-1:0]  cfg_wdata_i,
  rse_in_if.sink                           data_in,
  rse_out_if.source                        code_out
);
  import rse_pkg::*;

  logic [CountW-1:0] n_q, n_d;
  logic [CountW-1:0] gen_cnt_q, gen_cnt_d;
  logic [SymW-1:0]   root_q, root_d;
  logic [CountW-1:0] drain_q, drain_d;
  logic              out_valid_q, out_valid_d;
  logic [SymW-1:0]   out_byte_q, out_byte_d;
  logic              is_parity_q, is_parity_d;
  logic              eoc_q, eoc_d;

  logic [CountW-1:0] n_wr;
  logic              load_ok;
  logic              in_acc;
  logic              shift_out;
  cell_ctrl_t        ctrl;

  logic [SymW-1:0] p_w  [MaxParity+1];
  logic [SymW-1:0] sh_w [MaxParity+1];
  logic [SymW-1:0] g_w  [MaxParity];

  // saturate the written count into 1..MaxParity
  always_comb begin
    if (cfg_wdata_i == '0) begin
      n_wr = CountW'(1);
    end else if (cfg_wdata_i > CountW'(MaxParity)) begin
      n_wr = CountW'(MaxParity);
    end else begin
      n_wr = cfg_wdata_i;
    end
  end

  assign load_ok       = !out_valid_q || code_out.ready;
  assign data_in.ready = load_ok && (drain_q == '0) && (gen_cnt_q == '0);
  assign in_acc        = data_in.valid && data_in.ready;
  assign shift_out     = (drain_q != '0) && load_ok;

  always_comb begin
    ctrl.cfg_clear = cfg_we_i;
    ctrl.accept    = in_acc;
    ctrl.last      = data_in.last_byte;
    ctrl.shift_out = shift_out;
    ctrl.gen_step  = (gen_cnt_q != '0) && !cfg_we_i;
    ctrl.fb        = data_in.data_byte ^ p_w[0];
    ctrl.root      = root_q;
  end

  assign p_w[MaxParity]  = '0;
  assign sh_w[MaxParity] = '0;

  for (genvar j = 0; j < MaxParity; j++) begin : g_cell
    logic [SymW-1:0] g_dn;
    if (j == 0) begin : g_lead
      // implied leading coefficient of the generator
      assign g_dn = SymW'(1);
    end else begin : g_mid
      assign g_dn = g_w[j-1];
    end
    rse_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .p_up_i  (p_w[j+1]),
      .g_dn_i  (g_dn),
      .sh_up_i (sh_w[j+1]),
      .p_o     (p_w[j]),
      .g_o     (g_w[j]),
      .sh_o    (sh_w[j])
    );
  end

  always_comb begin
    n_d       = n_q;
    gen_cnt_d = gen_cnt_q;
    root_d    = root_q;
    if (cfg_we_i) begin
      n_d       = n_wr;
      gen_cnt_d = n_wr;
      root_d    = SymW'(1);
    end else if (gen_cnt_q != '0) begin
      gen_cnt_d = gen_cnt_q - CountW'(1);
      root_d    = gf_xtime(root_q);
    end
  end

  always_comb begin
    drain_d     = drain_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    is_parity_d = is_parity_q;
    eoc_d       = eoc_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
      out_byte_d  = data_in.data_byte;
      is_parity_d = 1'b0;
      eoc_d       = 1'b0;
      if (data_in.last_byte) begin
        drain_d = n_q;
      end
    end else if (shift_out) begin
      out_valid_d = 1'b1;
      out_byte_d  = sh_w[0];
      is_parity_d = 1'b1;
      eoc_d       = (drain_q == CountW'(1));
      drain_d     = drain_q - CountW'(1);
    end else if (code_out.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= CountW'(ResetParity);
      gen_cnt_q   <= CountW'(ResetParity);
      root_q      <= SymW'(1);
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      n_q         <= n_d;
      gen_cnt_q   <= gen_cnt_d;
      root_q      <= root_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q  <= out_byte_d;
    is_parity_q <= is_parity_d;
    eoc_q       <= eoc_d;
  end

  assign code_out.valid           = out_valid_q;
  assign code_out.out_byte        = out_byte_q;
  assign code_out.is_parity       = is_parity_q;
  assign code_out.end_of_codeword = eoc_q;

  // a last byte starts a drain of exactly n parity bytes
  `RSE_ASSERT_NEXT(a_drain_len, clk_i, rst_ni, in_acc && data_in.last_byte, drain_q == $past(n_q))
  // the final parity transfer is the one flagged end of codeword
  `RSE_ASSERT_NEXT(a_eoc_mark, clk_i, rst_ni, drain_q == CountW'(1) && load_ok, out_valid_q && eoc_q)
  // end of codeword only ever sits on a parity symbol
  `RSE_ASSERT_SAME(a_eoc_parity, clk_i, rst_ni, out_valid_q && eoc_q, is_parity_q)

endmodule

`default_nettype wire

[rtl/rse_cell.sv]
`default_nettype none

module rse_cell (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire rse_pkg::cell_ctrl_t       ctrl_i,
  input  wire logic [rse_pkg::SymW-1:0]  p_up_i,
  input  wire logic [rse_pkg::SymW-1:0]  g_dn_i,
  input  wire logic [rse_pkg::SymW-1:0]  sh_up_i,
  output logic      [rse_pkg::SymW-1:0]  p_o,
  output logic      [rse_pkg::SymW-1:0]  g_o,
  output logic      [rse_pkg::SymW-1:0]  sh_o
);
  import rse_pkg::*;

  logic [SymW-1:0] p_q, p_d;
  logic [SymW-1:0] g_q, g_d;
  logic [SymW-1:0] sh_q, sh_d;
  logic [SymW-1:0] p_next;

  // lfsr stage: upper neighbor plus coefficient times feedback
  assign p_next = p_up_i ^ gf_mul(g_q, ctrl_i.fb);

  always_comb begin
    p_d  = p_q;
    g_d  = g_q;
    sh_d = sh_q;
    if (ctrl_i.cfg_clear) begin
      p_d = '0;
      g_d = '0;
    end else begin
      if (ctrl_i.accept) begin
        p_d = ctrl_i.last ? '0 : p_next;
      end
      // one generator factor (x + root) per step
      if (ctrl_i.gen_step) begin
        g_d = g_q ^ gf_mul(ctrl_i.root, g_dn_i);
      end
    end
    if (ctrl_i.accept && ctrl_i.last) begin
      sh_d = p_next;
    end else if (ctrl_i.shift_out) begin
      sh_d = sh_up_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_q <= '0;
      g_q <= '0;
    end else begin
      p_q <= p_d;
      g_q <= g_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q <= sh_d;
  end

  assign p_o  = p_q;
  assign g_o  = g_q;
  assign sh_o = sh_q;

endmodule

`default_nettype wire

[sim/rse_checker.sv]
`timescale 1ns / 1ps

module rse_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rse_pkg::CountW-1:0] cfg_wdata_i,
  rse_in_if                          in_mon,
  rse_out_if                         out_mon,
  output int unsigned                fail_cnt_o,
  output int unsigned                pending_o
);
  import rse_pkg::*;

  typedef struct packed {
    logic [SymW-1:0] sym;
    logic            parity;
    logic            eoc;
  } code_sym_t;

  logic [SymW-1:0] lfsr_q   [MaxParity];
  logic [SymW-1:0] gen_coef [MaxParity];
  int unsigned     parity_n;
  code_sym_t       expected_syms [$];

  function automatic logic [SymW-1:0] gf256_times(input logic [SymW-1:0] a,
                                                  input logic [SymW-1:0] b);
    logic [SymW:0]   x;
    logic [SymW-1:0] acc;
    x   = {1'b0, a};
    acc = '0;
    for (int i = 0; i < SymW; i++) begin
      if (b[i]) begin
        acc = acc ^ x[SymW-1:0];
      end
      x = x << 1;
      if ((x & FieldTop) != '0) begin
        x = x ^ FieldPoly;
      end
    end
    return acc;
  endfunction

  function automatic int unsigned saturate_count(input logic [CountW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxParity) return MaxParity;
    return int'(v);
  endfunction

  // rebuilds g(x) = prod (x + alpha^i) and clears the parity stages
  function automatic void apply_parity_count(input int unsigned n);
    logic [SymW-1:0] poly [MaxParity+1];
    logic [SymW-1:0] root;
    for (int k = 0; k <= MaxParity; k++) begin
      poly[k] = '0;
    end
    poly[0] = 8'h01;
    root    = 8'h01;
    for (int i = 0; i < n; i++) begin
      for (int k = i + 1; k > 0; k--) begin
        poly[k] = poly[k] ^ gf256_times(root, poly[k-1]);
      end
      root = gf256_times(root, 8'h02);
    end
    for (int k = 0; k < MaxParity; k++) begin
      gen_coef[k] = (k < n) ? poly[k+1] : '0;
      lfsr_q[k]   = '0;
    end
    parity_n = n;
  endfunction

  function automatic void encode_byte(input logic [SymW-1:0] d, input logic l);
    logic [SymW-1:0] fb;
    fb = d ^ lfsr_q[0];
    for (int j = 0; j + 1 < parity_n; j++) begin
      lfsr_q[j] = lfsr_q[j+1] ^ gf256_times(gen_coef[j], fb);
    end
    lfsr_q[parity_n-1] = gf256_times(gen_coef[parity_n-1], fb);
    expected_syms.push_back('{sym: d, parity: 1'b0, eoc: 1'b0});
    if (l) begin
      // parity leaves top stage first
      for (int j = 0; j < parity_n; j++) begin
        expected_syms.push_back('{sym: lfsr_q[j], parity: 1'b1,
                                  eoc: (j + 1 == parity_n)});
      end
      for (int j = 0; j < MaxParity; j++) begin
        lfsr_q[j] = '0;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    code_sym_t head;
    if (!rst_ni) begin
      expected_syms.delete();
      apply_parity_count(ResetParity);
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_syms.size() == 0) begin
          $error("unexpected transfer: out_byte %02h is_parity %0b end_of_codeword %0b",
                 out_mon.out_byte, out_mon.is_parity, out_mon.end_of_codeword);
          fail_cnt_o++;
        end else begin
          head = expected_syms.pop_front();
          if (out_mon.out_byte !== head.sym) begin
            $error("out_byte: expected %02h, actual %02h", head.sym, out_mon.out_byte);
            fail_cnt_o++;
          end
          if (out_mon.is_parity !== head.parity) begin
            $error("is_parity: expected %0b, actual %0b", head.parity, out_mon.is_parity);
            fail_cnt_o++;
          end
          if (out_mon.end_of_codeword !== head.eoc) begin
            $error("end_of_codeword: expected %0b, actual %0b",
                   head.eoc, out_mon.end_of_codeword);
            fail_cnt_o++;
          end
        end
      end
      if (cfg_we_i) begin
        apply_parity_count(saturate_count(cfg_wdata_i));
      end
      if (in_mon.valid && in_mon.ready) begin
        encode_byte(in_mon.data_byte, in_mon.last_byte);
      end
      pending_o = expected_syms.size();
    end
  end

endmodule

[sim/tb_reed_solomon_systematic_encoder.sv]
`timescale 1ns / 1ps

module tb_reed_solomon_systematic_encoder;
  import rse_pkg::*;

  localparam int unsigned Limit = 400000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we;
  logic [CountW-1:0] cfg_wdata;
  int unsigned       send_idle_pct;
  int unsigned       recv_idle_pct;
  int unsigned       fail_cnt;
  int unsigned       pending;
  int unsigned       cycle_cnt;

  rse_in_if  in_ch ();
  rse_out_if out_ch ();

  always #5 clk_i = ~clk_i;

  reed_solomon_systematic_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .data_in     (in_ch.sink),
    .code_out    (out_ch.source)
  );

  rse_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (pending)
  );

  // receiver back-pressure
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < Limit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic send_byte(input logic [SymW-1:0] d, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= l;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic send_message(input int unsigned len);
    for (int i = 0; i < len; i++) begin
      send_byte(SymW'($urandom), i == len - 1);
    end
  endtask

  // hold off input until every codeword symbol has come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_parity(input logic [CountW-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [CountW-1:0] pick_parity();
    case ($urandom_range(4))
      0:       return '0;
      1:       return CountW'(1);
      2:       return CountW'(MaxParity);
      3:       return '1;
      default: return CountW'($urandom_range(63));
    endcase
  endfunction

  task automatic run_random(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(3) == 0) begin
        write_parity(pick_parity());
      end
      if ($urandom_range(7) == 0) begin
        // abandoned message, parity restarted by the write
        len = $urandom_range(4, 1);
        for (int i = 0; i < len; i++) begin
          send_byte(SymW'($urandom), 1'b0);
        end
        sent += len;
        write_parity(pick_parity());
      end
      len = $urandom_range(12, 1);
      send_message(len);
      sent += len;
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.data_byte <= '0;
    in_ch.last_byte <= 1'b0;
    send_idle_pct   = 19;
    recv_idle_pct   = 63;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset parity count
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hff, 1'b1);
    write_parity(CountW'(1));
    send_byte(8'haa, 1'b0);
    send_byte(8'h55, 1'b1);
    write_parity(CountW'(MaxParity));
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    // write in the middle of a message clears the parity
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    write_parity('0);
    send_byte(8'h9c, 1'b0);
    send_byte(8'h01, 1'b1);
    write_parity('1);
    send_byte(8'h7f, 1'b0);
    send_byte(8'hfe, 1'b1);
    write_parity(CountW'(MaxParity + 1));
    send_byte(8'h3c, 1'b1);

    run_random(45);
    drain();
    send_idle_pct <= 63;
    recv_idle_pct <= 19;
    run_random(45);
    drain();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    run_random(45);
    write_parity(CountW'(ResetParity));
    send_message(5);

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+rtl
rtl/rse_pkg.sv
rtl/rse_if.sv
rtl/rse_cell.sv
rtl/reed_solomon_systematic_encoder.sv
sim/rse_checker.sv
sim/tb_reed_solomon_systematic_encoder.sv
